FILE: rtl/core/free_list_allocator_assert.svh
// assertion macros for the free list allocator
`ifndef FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FLA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");
`define FLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");
`else
`define FLA_ASSERT_SAME(label, clk, rst, ante, cons)
`define FLA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/fla_pkg.sv
// shared types and constants for the free list allocator
package fla_pkg;

   localparam int ARENA_UNITS = 4096;
   localparam int UNIT_BYTES  = 16;
   localparam int UNIT_SHIFT  = $clog2(UNIT_BYTES);
   localparam int IDX_W       = $clog2(ARENA_UNITS);
   localparam int SIZE_W      = IDX_W + 1;
   localparam int WALK_LIMIT  = 3 * ARENA_UNITS + 4;
   localparam int CNT_W       = $clog2(WALK_LIMIT + 1);
   localparam int BYTES_W     = 16;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [SIZE_W-1:0] ARENA_RESET    = SIZE_W'(4096);
   localparam logic [SIZE_W-1:0] MIN_GROW_RESET = SIZE_W'(1024);

   localparam logic REG_ARENA_UNITS    = 1'b0;
   localparam logic REG_MIN_GROW_UNITS = 1'b1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_OOM  = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [BYTES_W-1:0] request_bytes;
      logic [IDX_W-1:0]   block_unit;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [IDX_W-1:0] payload_unit;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]  next;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   typedef struct packed {
      logic [SIZE_W-1:0] arena_units;
      logic [SIZE_W-1:0] min_grow_units;
   } cfg_type;

   typedef enum logic [4:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_A_START,
      CMD_A_TAKE_PREV,
      CMD_A_RD_P,
      CMD_A_LATCH,
      CMD_A_ADV,
      CMD_A_UNLINK,
      CMD_A_CUT1,
      CMD_A_CUT2,
      CMD_A_FAIL,
      CMD_A_GROW,
      CMD_A_REROV,
      CMD_R_START,
      CMD_R_RD,
      CMD_R_CHK,
      CMD_R_RDB,
      CMD_R_GETB,
      CMD_R_MERGE,
      CMD_R_LINK,
      CMD_RESULT
   } cmd_type;

   typedef struct packed {
      logic fit;
      logic exact;
      logic at_rover;
      logic alim;
      logic grow_ok;
      logic found;
      logic rlim;
      logic free_ok;
   } stat_type;

endpackage

FILE: rtl/core/fla_datapath.sv
// header store, list pointers and arithmetic of the free list allocator
module fla_datapath (
   input  logic              clock,
   input  logic              reset,
   input  fla_pkg::cmd_type  cmd,
   input  fla_pkg::req_type  req_data,
   input  fla_pkg::cfg_type  cfg,
   output fla_pkg::stat_type stat,
   output fla_pkg::rsp_type  rsp_data
);
   import fla_pkg::*;

   hdr_type mem [ARENA_UNITS];

   hdr_type            header0_ff, rd0_ff, mem_rd_ff, cur_ff, b_ff, rd;
   logic               sel0_ff;
   logic [IDX_W-1:0]   rover_ff, p_ff, prev_ff, blk_ff, bp_ff;
   logic [SIZE_W-1:0]  break_ff, prev_size_ff, need_ff, bsz_ff;
   logic [CNT_W-1:0]   acnt_ff, rcnt_ff;
   rsp_type            res_ff, rsp_ff;

   logic [BYTES_W:0]   bytes_up;
   logic [SIZE_W-1:0]  need_in, nu, limit, cut_size;
   logic [IDX_W-1:0]   cut_at, raddr, waddr;
   logic               ren, wen, hi, lo;
   hdr_type            wdata, b_in;

   assign rd = sel0_ff ? rd0_ff : mem_rd_ff;

   assign bytes_up = {1'b0, req_data.request_bytes} + (BYTES_W+1)'(UNIT_BYTES - 1);
   assign need_in  = SIZE_W'(bytes_up >> UNIT_SHIFT) + SIZE_W'(1);

   assign nu    = (need_ff < cfg.min_grow_units) ? cfg.min_grow_units : need_ff;
   assign limit = (cfg.arena_units < SIZE_W'(ARENA_UNITS)) ? cfg.arena_units
                                                           : SIZE_W'(ARENA_UNITS);

   assign cut_size = cur_ff.size - need_ff;
   assign cut_at   = p_ff + cut_size[IDX_W-1:0];

   // upper neighbor adjoins the freed block
   assign hi = ((SIZE_W+1)'(bp_ff) + (SIZE_W+1)'(bsz_ff)) == (SIZE_W+1)'(cur_ff.next);
   assign b_in.next = hi ? rd.next : cur_ff.next;
   assign b_in.size = hi ? (bsz_ff + rd.size) : bsz_ff;
   // lower neighbor adjoins the freed block
   assign lo = ((SIZE_W+1)'(p_ff) + (SIZE_W+1)'(cur_ff.size)) == (SIZE_W+1)'(bp_ff);

   always_comb begin
      stat.fit      = rd.size >= need_ff;
      stat.exact    = rd.size == need_ff;
      stat.at_rover = p_ff == rover_ff;
      stat.alim     = acnt_ff == CNT_W'(WALK_LIMIT - 1);
      stat.grow_ok  = !(nu > limit) && !(break_ff > (limit - nu));
      stat.found    = ((bp_ff > p_ff) && (bp_ff < rd.next)) ||
                      ((p_ff >= rd.next) && ((bp_ff > p_ff) || (bp_ff < rd.next)));
      stat.rlim     = rcnt_ff == CNT_W'(WALK_LIMIT);
      stat.free_ok  = (blk_ff >= IDX_W'(2)) &&
                      ({1'b0, blk_ff - IDX_W'(1)} < break_ff);
   end

   always_comb begin
      ren   = 1'b0;
      raddr = p_ff;
      wen   = 1'b0;
      waddr = p_ff;
      wdata = cur_ff;
      case (cmd)
         CMD_A_START, CMD_A_REROV: begin
            ren   = 1'b1;
            raddr = rover_ff;
         end
         CMD_A_RD_P, CMD_R_RD: begin
            ren = 1'b1;
         end
         CMD_R_RDB: begin
            ren   = 1'b1;
            raddr = bp_ff;
         end
         CMD_R_GETB: begin
            ren   = 1'b1;
            raddr = cur_ff.next;
         end
         CMD_A_UNLINK: begin
            wen   = 1'b1;
            waddr = prev_ff;
            wdata = '{next: cur_ff.next, size: prev_size_ff};
         end
         CMD_A_CUT1: begin
            wen   = 1'b1;
            wdata = '{next: cur_ff.next, size: cut_size};
         end
         CMD_A_CUT2: begin
            wen   = 1'b1;
            wdata = '{next: '0, size: need_ff};
         end
         CMD_A_GROW: begin
            wen   = 1'b1;
            waddr = break_ff[IDX_W-1:0];
            wdata = '{next: '0, size: nu};
         end
         CMD_R_MERGE: begin
            wen   = 1'b1;
            waddr = bp_ff;
            wdata = b_in;
         end
         CMD_R_LINK: begin
            wen   = 1'b1;
            wdata = lo ? '{next: b_ff.next, size: cur_ff.size + b_ff.size}
                       : '{next: bp_ff, size: cur_ff.size};
         end
         default: begin
            ren = 1'b0;
         end
      endcase
   end

   // unit 0 lives in flops so the sentinel is valid right after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         header0_ff <= '0;
         sel0_ff    <= 1'b0;
         rd0_ff     <= '0;
         rover_ff   <= '0;
         break_ff   <= SIZE_W'(1);
      end else begin
         if (ren) begin
            sel0_ff <= raddr == '0;
            rd0_ff  <= header0_ff;
         end
         if (wen && (waddr == '0)) begin
            header0_ff <= wdata;
         end
         case (cmd)
            CMD_A_UNLINK, CMD_A_CUT2: rover_ff <= prev_ff;
            CMD_R_LINK:               rover_ff <= p_ff;
            CMD_A_GROW:               break_ff <= break_ff + nu;
            default:                  rover_ff <= rover_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ren) begin
         mem_rd_ff <= mem[raddr];
      end
      if (wen && (waddr != '0)) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            need_ff <= need_in;
            blk_ff  <= req_data.block_unit;
            res_ff  <= '{status: STATUS_DONE, payload_unit: '0};
         end
         CMD_A_START: begin
            prev_ff <= rover_ff;
            acnt_ff <= '0;
         end
         CMD_A_TAKE_PREV: begin
            prev_size_ff <= rd.size;
            p_ff         <= rd.next;
         end
         CMD_A_LATCH: begin
            cur_ff <= rd;
         end
         CMD_A_ADV: begin
            prev_ff      <= p_ff;
            prev_size_ff <= cur_ff.size;
            p_ff         <= cur_ff.next;
            acnt_ff      <= acnt_ff + CNT_W'(1);
         end
         CMD_A_UNLINK: begin
            res_ff.payload_unit <= p_ff + IDX_W'(1);
         end
         CMD_A_CUT1: begin
            p_ff <= cut_at;
         end
         CMD_A_CUT2: begin
            res_ff.payload_unit <= p_ff + IDX_W'(1);
         end
         CMD_A_FAIL: begin
            res_ff <= '{status: STATUS_OOM, payload_unit: '0};
         end
         CMD_A_GROW: begin
            bp_ff   <= break_ff[IDX_W-1:0];
            p_ff    <= rover_ff;
            rcnt_ff <= '0;
         end
         CMD_A_REROV: begin
            p_ff <= rover_ff;
         end
         CMD_R_START: begin
            bp_ff   <= blk_ff - IDX_W'(1);
            p_ff    <= rover_ff;
            rcnt_ff <= '0;
         end
         CMD_R_CHK: begin
            cur_ff <= rd;
            if (!stat.found) begin
               p_ff    <= rd.next;
               rcnt_ff <= rcnt_ff + CNT_W'(1);
            end
         end
         CMD_R_GETB: begin
            bsz_ff <= rd.size;
         end
         CMD_R_MERGE: begin
            b_ff <= b_in;
         end
         CMD_RESULT: begin
            rsp_ff <= res_ff;
         end
         default: begin
            rsp_ff <= rsp_ff;
         end
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/core/fla_ctrl.sv
// sequencer for allocate and free walks of the free list allocator
module fla_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              operation,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  fla_pkg::stat_type stat,
   output fla_pkg::cmd_type  cmd
);
   import fla_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_A_START, S_A_PREV, S_A_RD, S_A_CHK, S_A_ADV, S_A_UNLINK,
      S_A_CUT1, S_A_CUT2, S_A_GROW, S_A_REROV, S_A_RELAT, S_F_CHK,
      S_R_RD, S_R_CHK, S_R_RDB, S_R_GETB, S_R_MERGE, S_R_LINK, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      grow_ff, grow_in, rsp_valid_ff, rsp_valid_in;
   logic      rel_end;
   state_type rel_next;

   // after a release, an allocate that grew resumes its walk at the rover
   assign rel_next = grow_ff ? S_A_REROV : S_OUT;

   always_comb begin
      state_in     = state_ff;
      grow_in      = grow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = CMD_IDLE;
      rel_end      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = (operation == OP_FREE) ? S_F_CHK : S_A_START;
            end
         end
         S_A_START: begin
            cmd      = CMD_A_START;
            state_in = S_A_PREV;
         end
         S_A_PREV: begin
            cmd      = CMD_A_TAKE_PREV;
            state_in = S_A_RD;
         end
         S_A_RD: begin
            cmd      = CMD_A_RD_P;
            state_in = S_A_CHK;
         end
         S_A_CHK: begin
            cmd = CMD_A_LATCH;
            if (stat.fit && stat.exact)  state_in = S_A_UNLINK;
            else if (stat.fit)           state_in = S_A_CUT1;
            else if (stat.at_rover)      state_in = S_A_GROW;
            else                         state_in = S_A_ADV;
         end
         S_A_ADV: begin
            if (stat.alim) begin
               cmd      = CMD_A_FAIL;
               state_in = S_OUT;
            end else begin
               cmd      = CMD_A_ADV;
               state_in = S_A_RD;
            end
         end
         S_A_UNLINK: begin
            cmd      = CMD_A_UNLINK;
            state_in = S_OUT;
         end
         S_A_CUT1: begin
            cmd      = CMD_A_CUT1;
            state_in = S_A_CUT2;
         end
         S_A_CUT2: begin
            cmd      = CMD_A_CUT2;
            state_in = S_OUT;
         end
         S_A_GROW: begin
            if (stat.grow_ok) begin
               cmd      = CMD_A_GROW;
               grow_in  = 1'b1;
               state_in = S_R_RD;
            end else begin
               cmd      = CMD_A_FAIL;
               state_in = S_OUT;
            end
         end
         S_A_REROV: begin
            cmd      = CMD_A_REROV;
            grow_in  = 1'b0;
            state_in = S_A_RELAT;
         end
         S_A_RELAT: begin
            cmd      = CMD_A_LATCH;
            state_in = S_A_ADV;
         end
         S_F_CHK: begin
            if (stat.free_ok) begin
               cmd      = CMD_R_START;
               state_in = S_R_RD;
            end else begin
               state_in = S_OUT;
            end
         end
         S_R_RD: begin
            cmd      = CMD_R_RD;
            state_in = S_R_CHK;
         end
         S_R_CHK: begin
            cmd = CMD_R_CHK;
            if (stat.found)     state_in = S_R_RDB;
            else if (stat.rlim) rel_end  = 1'b1;
            else                state_in = S_R_RD;
         end
         S_R_RDB: begin
            cmd      = CMD_R_RDB;
            state_in = S_R_GETB;
         end
         S_R_GETB: begin
            cmd      = CMD_R_GETB;
            state_in = S_R_MERGE;
         end
         S_R_MERGE: begin
            cmd      = CMD_R_MERGE;
            state_in = S_R_LINK;
         end
         S_R_LINK: begin
            cmd     = CMD_R_LINK;
            rel_end = 1'b1;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd          = CMD_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (rel_end) begin
         state_in = rel_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         grow_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         grow_ff      <= grow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/free_list_allocator.sv
// top level of the next-fit free list allocator
//
// channel  direction  handshake             beat
// req      in         req_valid/req_ready   operation, request_bytes, block_unit
// rsp      out        rsp_valid/rsp_ready   status, payload_unit
// csr      in         apb psel/penable      arena_units @0, min_grow_units @4
//
// one item at a time; the header store has one read and one write port and the
// walk visits one free-list header per memory read.
// allocate: a split takes one more step than an exact fit, and growth adds a
// release walk; free: walks headers to the insertion point, drops go straight to the result.
// the store needs no clearing pass after reset, unit 0 sits in flops.
// a finished result waits in the output register while the next item is taken.
module free_list_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  fla_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output fla_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fla_pkg::CSR_AW-1:0]     paddr,
   input  logic [fla_pkg::CSR_DW-1:0]     pwdata,
   output logic [fla_pkg::CSR_DW-1:0]     prdata,
   output logic                           pready
);
   import fla_pkg::*;

   cfg_type  cfg_ff;
   stat_type stat;
   cmd_type  cmd;
   logic     csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arena_units    <= ARENA_RESET;
         cfg_ff.min_grow_units <= MIN_GROW_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == REG_ARENA_UNITS) begin
            cfg_ff.arena_units <= pwdata[SIZE_W-1:0];
         end else begin
            cfg_ff.min_grow_units <= pwdata[SIZE_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_ARENA_UNITS) ? CSR_DW'(cfg_ff.arena_units)
                                                 : CSR_DW'(cfg_ff.min_grow_units);

   fla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .operation (req_data.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fla_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

`include "free_list_allocator_assert.svh"

   `FLA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `FLA_ASSERT_SAME(a_oom_no_unit, clock, reset, rsp_valid && (rsp_data.status == STATUS_OOM), rsp_data.payload_unit == '0)
   `FLA_ASSERT_NEXT(a_rsp_needs_item, clock, reset, !rsp_valid && req_ready, !rsp_valid)

endmodule

FILE: test/tb_top.sv
// testbench for the next-fit free list allocator: predicting scoreboard and drivers
`timescale 1ns / 1ps

module tb_top;
   import fla_pkg::*;

   class alloc_scoreboard;
      int unsigned hdr_next [ARENA_UNITS];
      int unsigned hdr_size [ARENA_UNITS];
      int unsigned rover;
      int unsigned brk;
      int unsigned arena_lim;
      int unsigned min_grow;
      rsp_type     pending_q[$];
      int unsigned live_q[$];
      int          errors;

      function new();
         foreach (hdr_next[i]) begin
            hdr_next[i] = 0;
            hdr_size[i] = 0;
         end
         rover     = 0;
         brk       = 1;
         arena_lim = 4096;
         min_grow  = 1024;
         errors    = 0;
      endfunction

      function void set_reg(logic idx, int unsigned value);
         if (idx == REG_ARENA_UNITS) arena_lim = value & 32'h1fff;
         else min_grow = value & 32'h1fff;
      endfunction

      // insert block by address and merge with both neighbors
      function void insert_block(int unsigned bp_in);
         int unsigned p, nx, bp, steps;
         p = rover;
         bp = bp_in % ARENA_UNITS;
         steps = 0;
         forever begin
            nx = hdr_next[p];
            if (bp > p && bp < nx) break;
            if (p >= nx && (bp > p || bp < nx)) break;
            p = nx;
            steps++;
            if (steps > WALK_LIMIT) return;
         end
         nx = hdr_next[p];
         if (bp + hdr_size[bp] == nx) begin
            hdr_size[bp] += hdr_size[nx];
            hdr_next[bp] = hdr_next[nx];
         end else begin
            hdr_next[bp] = nx;
         end
         if (p + hdr_size[p] == bp) begin
            hdr_size[p] += hdr_size[bp];
            hdr_next[p] = hdr_next[bp];
         end else begin
            hdr_next[p] = bp;
         end
         rover = p;
      endfunction

      function bit extend_arena(int unsigned need);
         int unsigned nu, lim, h;
         nu = (need < min_grow) ? min_grow : need;
         lim = (arena_lim < ARENA_UNITS) ? arena_lim : ARENA_UNITS;
         if (nu > lim || brk > lim - nu) return 0;
         h = brk;
         hdr_size[h % ARENA_UNITS] = nu;
         brk = h + nu;
         insert_block(h);
         return 1;
      endfunction

      // returns header unit, or -1 when out of memory
      function int carve_block(int unsigned nbytes);
         int unsigned need, prev, p, steps;
         need = (nbytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
         prev = rover;
         p = hdr_next[prev];
         for (steps = 0; steps < WALK_LIMIT; steps++) begin
            if (hdr_size[p] >= need) begin
               if (hdr_size[p] == need) begin
                  hdr_next[prev] = hdr_next[p];
               end else begin
                  hdr_size[p] -= need;
                  p = (p + hdr_size[p]) % ARENA_UNITS;
                  hdr_size[p] = need;
               end
               rover = prev;
               return int'(p);
            end
            if (p == rover) begin
               if (!extend_arena(need)) return -1;
               p = rover;
            end
            prev = p;
            p = hdr_next[p];
         end
         return -1;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int h;
         e.status = STATUS_DONE;
         e.payload_unit = '0;
         if (r.operation == OP_ALLOC) begin
            h = carve_block(r.request_bytes);
            if (h < 0) begin
               e.status = STATUS_OOM;
            end else begin
               e.payload_unit = IDX_W'(h + 1);
               if (h + 1 < ARENA_UNITS) live_q.push_back(h + 1);
            end
         end else if (r.block_unit >= 2 && r.block_unit - 1 < brk) begin
            insert_block(r.block_unit - 1);
         end
         pending_q.push_back(e);
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected beat status=%0d payload=%0d",
                             a.status, a.payload_unit));
            return;
         end
         e = pending_q.pop_front();
         if (a.status !== e.status)
            report($sformatf("status expected %0d actual %0d", e.status, a.status));
         if (a.payload_unit !== e.payload_unit)
            report($sformatf("payload_unit expected %0d actual %0d",
                             e.payload_unit, a.payload_unit));
      endfunction

      function int unsigned take_live();
         int unsigned k, v;
         k = $urandom_range(live_q.size() - 1);
         v = live_q[k];
         live_q.delete(k);
         return v;
      endfunction

      // a block unit that the block must drop
      function int unsigned bogus_block();
         int unsigned v;
         v = $urandom_range(4095);
         if (v >= 2 && v - 1 < brk) v = $urandom_range(1);
         return v;
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic             pready;

   alloc_scoreboard sb;
   int  tx_idle_pct;
   int  rx_stall_pct;
   bit  hold_req;

   free_list_allocator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2s;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   task automatic send_beat(req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic send_alloc(int unsigned nbytes);
      req_type r;
      r.operation = OP_ALLOC;
      r.request_bytes = BYTES_W'(nbytes);
      r.block_unit = IDX_W'($urandom);
      send_beat(r);
   endtask

   task automatic send_free(int unsigned blk);
      req_type r;
      r.operation = OP_FREE;
      r.request_bytes = BYTES_W'($urandom);
      r.block_unit = IDX_W'(blk);
      send_beat(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   task automatic configure(int unsigned arena, int unsigned grow);
      drain();
      csr_write(REG_ARENA_UNITS, arena);
      csr_write(REG_MIN_GROW_UNITS, grow);
   endtask

   task automatic run_random(int n);
      int roll, nb;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         if (roll < 55 || (roll < 93 && sb.live_q.size() == 0)) begin
            nb = $urandom_range(99);
            if (nb < 70) send_alloc($urandom_range(255));
            else if (nb < 95) send_alloc($urandom_range(2047));
            else send_alloc($urandom_range(65535));
         end else if (roll < 93) begin
            send_free(sb.take_live());
         end else begin
            send_free(sb.bogus_block());
         end
      end
   endtask

   initial begin
      sb = new();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_req     = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tiny arena: one unit fits, the next growth does not
      configure(2, 1);
      send_alloc(0);
      send_alloc(0);
      send_free(sb.take_live());
      send_free(0);
      send_free(1);
      send_free(4095);

      configure(4096, 1024);
      send_alloc(1);
      send_alloc(16);
      send_alloc(17);
      send_alloc(65535);
      send_alloc(1000);
      send_alloc(0);
      // frees in address-scattered order so neighbors merge
      while (sb.live_q.size() != 0) send_free(sb.take_live());
      send_alloc(16 * 1023 - 15);
      send_alloc(0);
      send_free(sb.take_live());

      run_random(200);
      configure(4096, 1);
      tx_idle_pct = 75;
      run_random(200);
      configure(300, 16);
      tx_idle_pct  = 0;
      rx_stall_pct = 75;
      hold_req     = 1;
      run_random(200);
      configure(4096, 4096);
      tx_idle_pct  = 38;
      rx_stall_pct = 38;
      run_random(200);
      configure(1000, 64);
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      run_random(200);

      drain();
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
